/* src/srfd_pkg.sv */
// ----------------------------------------------------------------------------
// srfd_pkg
// Shared constants, codes and types of the serial receive FIFO with frame
// delimiter.
// ----------------------------------------------------------------------------
package srfd_pkg;

  localparam int DEPTH    = 256;
  localparam int MAX_READ = 64;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_READ + 1);

  localparam int BYTE_W    = 8;
  localparam int COUNT_IN_W = 7;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;

  // wakeup when free space after the store drops below a quarter of the depth
  localparam logic [FILL_W-1:0] WAKE_FILL = FILL_W'(DEPTH - DEPTH / 4);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [KIND_W-1:0] KIND_RX    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_EN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTE = 2'd1;

  typedef struct packed {
    logic push;       // store a received word, emit status
    logic load;       // start a read burst
    logic pop;        // pop one word, emit it
    logic empty_rsp;  // read on empty store
  } srfd_cmd_t;

  typedef struct packed {
    logic empty;
    logic stop;       // word popped this cycle ends the burst
  } srfd_sts_t;

  function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] idx);
    next_idx = (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

/* src/srfd_ram.sv */
// ----------------------------------------------------------------------------
// srfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/srfd_ctrl.sv */
// ----------------------------------------------------------------------------
// srfd_ctrl
// Controller: accepts commands and sequences read bursts.
// ----------------------------------------------------------------------------
module srfd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                op,
  input  srfd_pkg::srfd_sts_t sts,
  output srfd_pkg::srfd_cmd_t cmd,
  output logic                busy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (op == srfd_pkg::OP_RX) begin
            cmd.push = 1'b1;
          end else if (sts.empty) begin
            cmd.empty_rsp = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.pop = 1'b1;
        if (sts.stop) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* src/srfd_dp.sv */
// ----------------------------------------------------------------------------
// srfd_dp
// Datapath: ring store, indices, fill and burst counters, config registers
// and the result register.
// ----------------------------------------------------------------------------
module srfd_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  srfd_pkg::srfd_cmd_t                    cmd,
  output srfd_pkg::srfd_sts_t                    sts,
  input  logic [srfd_pkg::BYTE_W-1:0]            in_rx_byte,
  input  logic [srfd_pkg::COUNT_IN_W-1:0]        in_max_count,
  input  logic                                   cfg_we,
  input  logic [srfd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [srfd_pkg::BYTE_W-1:0]            cfg_wdata,
  output logic                                   out_valid,
  output logic [srfd_pkg::KIND_W-1:0]            out_kind,
  output logic [srfd_pkg::BYTE_W-1:0]            out_data,
  output logic                                   out_last,
  output logic                                   out_wakeup,
  output logic                                   out_overflow
);

  logic [srfd_pkg::ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [srfd_pkg::ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [srfd_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [srfd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        dl_en_r;
  logic [srfd_pkg::BYTE_W-1:0] dl_byte_r;

  logic                        full;
  logic                        ram_we;
  logic [srfd_pkg::BYTE_W-1:0] rd_data;
  logic [srfd_pkg::FILL_W-1:0] fill_rx;
  logic                        wake;
  logic [srfd_pkg::CNT_W-1:0]  want;

  logic                        out_valid_r, out_valid_nxt;
  logic [srfd_pkg::KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [srfd_pkg::BYTE_W-1:0] out_data_r, out_data_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_wakeup_r, out_wakeup_nxt;
  logic                        out_overflow_r, out_overflow_nxt;

  assign full   = (fill_r == srfd_pkg::FULL_FILL);
  assign ram_we = cmd.push && !full;

  srfd_ram #(
    .WIDTH (srfd_pkg::BYTE_W),
    .DEPTH (srfd_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (in_rx_byte),
    .raddr (rd_idx_nxt),
    .rdata (rd_data)
  );

  assign fill_rx = full ? fill_r : fill_r + 1'b1;
  assign wake    = !dl_en_r || (in_rx_byte == dl_byte_r) || (fill_rx > srfd_pkg::WAKE_FILL);

  always_comb begin
    if (in_max_count == '0) begin
      want = srfd_pkg::CNT_W'(1);
    end else if (in_max_count > srfd_pkg::COUNT_IN_W'(srfd_pkg::MAX_READ)) begin
      want = srfd_pkg::CNT_W'(srfd_pkg::MAX_READ);
    end else begin
      want = srfd_pkg::CNT_W'(in_max_count);
    end
  end

  assign sts.empty = (fill_r == '0);
  assign sts.stop  = (fill_r == srfd_pkg::FILL_W'(1)) || (cnt_r == srfd_pkg::CNT_W'(1))
                     || (dl_en_r && (rd_data == dl_byte_r));

  always_comb begin
    wr_idx_nxt       = wr_idx_r;
    rd_idx_nxt       = rd_idx_r;
    fill_nxt         = fill_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = 1'b0;
    out_kind_nxt     = out_kind_r;
    out_data_nxt     = out_data_r;
    out_last_nxt     = out_last_r;
    out_wakeup_nxt   = out_wakeup_r;
    out_overflow_nxt = out_overflow_r;
    if (cmd.push) begin
      if (!full) begin
        wr_idx_nxt = srfd_pkg::next_idx(wr_idx_r);
      end
      fill_nxt         = fill_rx;
      out_valid_nxt    = 1'b1;
      out_kind_nxt     = srfd_pkg::KIND_RX;
      out_data_nxt     = '0;
      out_last_nxt     = 1'b1;
      out_wakeup_nxt   = wake;
      out_overflow_nxt = full;
    end
    if (cmd.empty_rsp) begin
      out_valid_nxt    = 1'b1;
      out_kind_nxt     = srfd_pkg::KIND_EMPTY;
      out_data_nxt     = '0;
      out_last_nxt     = 1'b1;
      out_wakeup_nxt   = 1'b0;
      out_overflow_nxt = 1'b0;
    end
    if (cmd.load) begin
      cnt_nxt = want;
    end
    if (cmd.pop) begin
      rd_idx_nxt       = srfd_pkg::next_idx(rd_idx_r);
      fill_nxt         = fill_r - 1'b1;
      cnt_nxt          = cnt_r - 1'b1;
      out_valid_nxt    = 1'b1;
      out_kind_nxt     = srfd_pkg::KIND_DATA;
      out_data_nxt     = rd_data;
      out_last_nxt     = sts.stop;
      out_wakeup_nxt   = 1'b0;
      out_overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      dl_en_r     <= 1'b0;
      dl_byte_r   <= '0;
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == srfd_pkg::REG_DELIM_EN)) begin
        dl_en_r <= cfg_wdata[0];
      end
      if (cfg_we && (cfg_index == srfd_pkg::REG_DELIM_BYTE)) begin
        dl_byte_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r     <= out_kind_nxt;
    out_data_r     <= out_data_nxt;
    out_last_r     <= out_last_nxt;
    out_wakeup_r   <= out_wakeup_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_data     = out_data_r;
  assign out_last     = out_last_r;
  assign out_wakeup   = out_wakeup_r;
  assign out_overflow = out_overflow_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= srfd_pkg::FULL_FILL)
    else $error("fill count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> fill_r != '0)
    else $error("pop on empty store");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !full) |=> fill_r == $past(fill_r) + 1'b1)
    else $error("fill count did not grow on push");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == srfd_pkg::KIND_EMPTY || out_kind == srfd_pkg::KIND_RX))
      |-> out_last)
    else $error("single-word response without last");

endmodule

/* src/serial_rx_fifo_frame_delimiter.sv */
// ----------------------------------------------------------------------------
// serial_rx_fifo_frame_delimiter
// Receive FIFO of a serial port with frame delimiter matching.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A receive word is
// handled as it is taken: its status result shows on the out_ ports the next
// cycle and the block is ready again at once. A read keeps busy high while its
// bytes are popped and delivers one byte per cycle through the result
// register, the pace being set by the single read port of the ring store; a
// read on an empty store answers with a single empty result. Each result is
// held for a single cycle with out_valid high and cannot be stalled. A full
// store drops the received byte and flags overflow. Configuration writes take
// effect at once and are meant to be issued while the block is idle.
module serial_rx_fifo_frame_delimiter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [srfd_pkg::BYTE_W-1:0]         in_rx_byte,
  input  logic [srfd_pkg::COUNT_IN_W-1:0]     in_max_count,
  output logic                                out_valid,
  output logic [srfd_pkg::KIND_W-1:0]         out_kind,
  output logic [srfd_pkg::BYTE_W-1:0]         out_data,
  output logic                                out_last,
  output logic                                out_wakeup,
  output logic                                out_overflow,
  input  logic                                cfg_we,
  input  logic [srfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srfd_pkg::BYTE_W-1:0]         cfg_wdata
);

  srfd_pkg::srfd_cmd_t cmd;
  srfd_pkg::srfd_sts_t sts;

  srfd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  srfd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_rx_byte   (in_rx_byte),
    .in_max_count (in_max_count),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_data     (out_data),
    .out_last     (out_last),
    .out_wakeup   (out_wakeup),
    .out_overflow (out_overflow)
  );

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for serial_rx_fifo_frame_delimiter. A short table of
// directed words (empty reads, byte extremes, count saturation, delimiter
// stops, ignored register indexes) is followed by random delimited frames
// under several delimiter settings and one pass that fills the store past
// overflow and drains it. Every result is compared against a table entry or a shadow FIFO.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH      = srfd_pkg::DEPTH;
  localparam int MAX_READ   = srfd_pkg::MAX_READ;
  localparam int ADDR_W     = srfd_pkg::ADDR_W;
  localparam int BYTE_W     = srfd_pkg::BYTE_W;
  localparam int COUNT_IN_W = srfd_pkg::COUNT_IN_W;
  localparam int KIND_W     = srfd_pkg::KIND_W;
  localparam int CFG_IDX_W  = srfd_pkg::CFG_IDX_W;

  localparam logic OP_RX   = srfd_pkg::OP_RX;
  localparam logic OP_READ = srfd_pkg::OP_READ;

  localparam logic [KIND_W-1:0] KIND_RX    = srfd_pkg::KIND_RX;
  localparam logic [KIND_W-1:0] KIND_DATA  = srfd_pkg::KIND_DATA;
  localparam logic [KIND_W-1:0] KIND_EMPTY = srfd_pkg::KIND_EMPTY;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_EN   = srfd_pkg::REG_DELIM_EN;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTE = srfd_pkg::REG_DELIM_BYTE;

  localparam int CYCLE_LIMIT = 200000;
  localparam int GAP_PCT     = 34;
  localparam int FRAME_ITEMS = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              wakeup;
    logic              overflow;
  } out_word_t;

  typedef enum logic [1:0] {ACT_RX, ACT_READ, ACT_CFG} plan_act_t;

  typedef struct packed {
    plan_act_t            act;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [BYTE_W-1:0]    arg;
    logic                 typed;
    out_word_t            exp_word;
  } plan_row_t;

  localparam out_word_t EMPTY_WORD = '{kind: KIND_EMPTY, data: '0, last: 1'b1,
                                       wakeup: 1'b0, overflow: 1'b0};
  localparam out_word_t RX_WAKE    = '{kind: KIND_RX, data: '0, last: 1'b1,
                                       wakeup: 1'b1, overflow: 1'b0};
  localparam out_word_t RX_QUIET   = '{kind: KIND_RX, data: '0, last: 1'b1,
                                       wakeup: 1'b0, overflow: 1'b0};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_op = OP_RX;
  logic [BYTE_W-1:0]       in_rx_byte = '0;
  logic [COUNT_IN_W-1:0]   in_max_count = '0;
  logic                    out_valid;
  logic [KIND_W-1:0]       out_kind;
  logic [BYTE_W-1:0]       out_data;
  logic                    out_last;
  logic                    out_wakeup;
  logic                    out_overflow;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [BYTE_W-1:0]       cfg_wdata = '0;

  serial_rx_fifo_frame_delimiter u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_rx_byte   (in_rx_byte),
    .in_max_count (in_max_count),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_data     (out_data),
    .out_last     (out_last),
    .out_wakeup   (out_wakeup),
    .out_overflow (out_overflow),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #2 clk = ~clk;

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // shadow copy of the ring store and its settings
  logic [BYTE_W-1:0] shadow_mem [DEPTH];
  logic [ADDR_W-1:0] shadow_wr = '0;
  logic [ADDR_W-1:0] shadow_rd = '0;
  int                shadow_fill = 0;
  logic              shadow_delim_en = 1'b0;
  logic [BYTE_W-1:0] shadow_delim = '0;

  out_word_t step_out[$];
  out_word_t pending_out[$];
  int        mismatch_count = 0;
  logic      gaps_on = 1'b1;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // results of one accepted word, left in step_out
  task automatic predict_fifo(input logic op, input logic [BYTE_W-1:0] b,
                              input logic [COUNT_IN_W-1:0] cnt);
    out_word_t w;
    int want;
    int n;
    logic [BYTE_W-1:0] c;
    logic stop;
    step_out.delete();
    if (op == OP_RX) begin
      w = RX_QUIET;
      w.overflow = (shadow_fill >= DEPTH);
      if (!w.overflow) begin
        shadow_mem[shadow_wr] = b;
        shadow_wr = shadow_wr + 1'b1;
        shadow_fill++;
      end
      w.wakeup = !shadow_delim_en || (b == shadow_delim) ||
                 ((DEPTH - shadow_fill) < DEPTH / 4);
      step_out.push_back(w);
    end else if (shadow_fill == 0) begin
      step_out.push_back(EMPTY_WORD);
    end else begin
      want = int'(cnt);
      if (want < 1) want = 1;
      if (want > MAX_READ) want = MAX_READ;
      n = 0;
      stop = 1'b0;
      while (shadow_fill != 0 && n < want && !stop) begin
        c = shadow_mem[shadow_rd];
        shadow_rd = shadow_rd + 1'b1;
        shadow_fill--;
        n++;
        stop = shadow_delim_en && (c == shadow_delim);
        w = '{kind: KIND_DATA, data: c, last: (shadow_fill == 0 || n == want || stop),
              wakeup: 1'b0, overflow: 1'b0};
        step_out.push_back(w);
      end
    end
  endtask

  task automatic send_word(input logic op, input logic [BYTE_W-1:0] b,
                           input logic [COUNT_IN_W-1:0] cnt, input logic typed,
                           input out_word_t exp_word);
    start <= 1'b1;
    in_op <= op;
    in_rx_byte <= b;
    in_max_count <= cnt;
    do @(posedge clk); while (busy);
    predict_fifo(op, b, cnt);
    if (typed) pending_out.push_back(exp_word);
    else foreach (step_out[i]) pending_out.push_back(step_out[i]);
    if (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < GAP_PCT);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_DELIM_EN) shadow_delim_en = val[0];
    else if (idx == REG_DELIM_BYTE) shadow_delim = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_delimiter(input logic en, input logic [BYTE_W-1:0] val);
    wait_idle();
    write_reg(REG_DELIM_EN, {7'($urandom_range(0, 127)), en});
    write_reg(REG_DELIM_BYTE, val);
    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 8'($urandom));
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    pick_byte = ($urandom_range(0, 3) == 0) ? shadow_delim : 8'($urandom);
  endfunction

  // delimited frames followed by a read, mixed with stray bytes and reads
  task automatic run_frames(input int n_items);
    int issued;
    int len;
    int r;
    logic [BYTE_W-1:0] b;
    logic [COUNT_IN_W-1:0] cnt;
    issued = 0;
    while (issued < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          b = (i == len - 1 && $urandom_range(0, 9) < 7) ? shadow_delim : pick_byte();
          send_word(OP_RX, b, 7'($urandom), 1'b0, '0);
        end
        cnt = $urandom_range(0, 1) ? 7'($urandom_range(len, len + 8))
                                   : 7'($urandom_range(0, 127));
        send_word(OP_READ, 8'($urandom), cnt, 1'b0, '0);
        issued += len + 1;
      end else if (r < 80) begin
        send_word(OP_RX, pick_byte(), 7'($urandom), 1'b0, '0);
        issued++;
      end else begin
        send_word(OP_READ, 8'($urandom), 7'($urandom_range(0, 127)), 1'b0, '0);
        issued++;
      end
    end
  endtask

  // run the store into overflow, then drain it to empty in reads of random length
  task automatic fill_store();
    while (shadow_fill < DEPTH) send_word(OP_RX, pick_byte(), 7'($urandom), 1'b0, '0);
    repeat (4) send_word(OP_RX, pick_byte(), 7'($urandom), 1'b0, '0);
    program_delimiter(1'b0, shadow_delim);
    while (shadow_fill > 0)
      send_word(OP_READ, 8'($urandom), 7'($urandom_range(0, 127)), 1'b0, '0);
    send_word(OP_READ, 8'($urandom), 7'($urandom_range(0, 127)), 1'b0, '0);
  endtask

  function automatic plan_row_t plan_row(input plan_act_t act, input logic [BYTE_W-1:0] arg,
                                         input logic typed, input out_word_t exp_word);
    plan_row = '{act: act, reg_idx: '0, arg: arg, typed: typed, exp_word: exp_word};
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [BYTE_W-1:0] val);
    cfg_row = '{act: ACT_CFG, reg_idx: idx, arg: val, typed: 1'b0, exp_word: '0};
  endfunction

  // result checker; results cannot be stalled
  out_word_t seen_word;
  out_word_t front_word;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen_word = '{kind: out_kind, data: out_data, last: out_last,
                    wakeup: out_wakeup, overflow: out_overflow};
      if (pending_out.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind %0d data %02h", out_kind, out_data));
      end else begin
        front_word = pending_out.pop_front();
        if (seen_word !== front_word)
          flag_mismatch($sformatf(
            "kind %0d/%0d data %02h/%02h last %0b/%0b wakeup %0b/%0b overflow %0b/%0b",
            seen_word.kind, front_word.kind, seen_word.data, front_word.data,
            seen_word.last, front_word.last, seen_word.wakeup, front_word.wakeup,
            seen_word.overflow, front_word.overflow));
      end
    end
  end

  initial begin
    plan_row_t directed_plan[$];

    directed_plan.push_back(plan_row(ACT_READ, 8'd1,   1'b1, EMPTY_WORD));
    directed_plan.push_back(plan_row(ACT_READ, 8'd0,   1'b1, EMPTY_WORD));
    directed_plan.push_back(plan_row(ACT_READ, 8'd127, 1'b1, EMPTY_WORD));
    directed_plan.push_back(plan_row(ACT_RX,   8'h00,  1'b1, RX_WAKE));
    directed_plan.push_back(plan_row(ACT_RX,   8'hFF,  1'b1, RX_WAKE));
    directed_plan.push_back(plan_row(ACT_RX,   8'hA5,  1'b1, RX_WAKE));
    directed_plan.push_back(plan_row(ACT_RX,   8'h5A,  1'b1, RX_WAKE));
    directed_plan.push_back(plan_row(ACT_READ, 8'd2,   1'b0, '0));
    directed_plan.push_back(plan_row(ACT_READ, 8'd64,  1'b0, '0));
    directed_plan.push_back(plan_row(ACT_READ, 8'd64,  1'b1, EMPTY_WORD));
    directed_plan.push_back(cfg_row(REG_DELIM_EN,   8'hFF));
    directed_plan.push_back(cfg_row(REG_DELIM_BYTE, 8'h7E));
    // out-of-range indexes must leave the delimiter alone
    directed_plan.push_back(cfg_row(REG_SPARE_2,    8'h11));
    directed_plan.push_back(cfg_row(REG_SPARE_3,    8'h22));
    directed_plan.push_back(plan_row(ACT_RX,   8'h11,  1'b1, RX_QUIET));
    directed_plan.push_back(plan_row(ACT_RX,   8'h7E,  1'b1, RX_WAKE));
    directed_plan.push_back(plan_row(ACT_RX,   8'h22,  1'b0, '0));
    directed_plan.push_back(plan_row(ACT_RX,   8'h7E,  1'b0, '0));
    directed_plan.push_back(plan_row(ACT_RX,   8'h7E,  1'b0, '0));
    directed_plan.push_back(plan_row(ACT_READ, 8'd64,  1'b0, '0));
    directed_plan.push_back(plan_row(ACT_READ, 8'd0,   1'b0, '0));
    directed_plan.push_back(plan_row(ACT_READ, 8'd3,   1'b0, '0));
    directed_plan.push_back(plan_row(ACT_READ, 8'd127, 1'b0, '0));
    directed_plan.push_back(plan_row(ACT_READ, 8'd5,   1'b1, EMPTY_WORD));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      case (directed_plan[i].act)
        ACT_CFG: begin
          wait_idle();
          write_reg(directed_plan[i].reg_idx, directed_plan[i].arg);
        end
        ACT_RX: begin
          send_word(OP_RX, directed_plan[i].arg, 7'($urandom),
                    directed_plan[i].typed, directed_plan[i].exp_word);
        end
        default: begin
          send_word(OP_READ, 8'($urandom), directed_plan[i].arg[COUNT_IN_W-1:0],
                    directed_plan[i].typed, directed_plan[i].exp_word);
        end
      endcase
    end

    program_delimiter(1'b1, 8'h00);
    run_frames(FRAME_ITEMS);
    gaps_on = 1'b0;
    program_delimiter(1'b1, 8'hFF);
    run_frames(FRAME_ITEMS);
    gaps_on = 1'b1;
    program_delimiter(1'b1, 8'($urandom));
    run_frames(FRAME_ITEMS);
    program_delimiter(1'b0, 8'($urandom));
    run_frames(FRAME_ITEMS);
    program_delimiter(1'b1, 8'($urandom));
    fill_store();

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_out.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", pending_out.size()));
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
